// ----- hw/rtl/idfa_pkg.sv -----
// idfa_pkg: shared types and constants for the ID allocator with free-list FIFO.
// Used by idfa_bitmap, idfa_free_fifo and id_allocator_free_fifo_core.
// No dependencies.
package idfa_pkg;

   // Number of IDs managed; the ID space is 0 .. MAX_IDS-1
   localparam int MAX_IDS = 1024;

   // Internal ID width and high-water width (0 .. MAX_IDS)
   localparam int ID_W = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
   localparam int HW_W = $clog2(MAX_IDS + 1);

   // Width of the ID fields on the ports
   localparam int PORT_ID_W = 10;

   // Width used to compare port IDs against the high-water mark
   localparam int CMP_W = (HW_W > PORT_ID_W) ? HW_W : PORT_ID_W;

   typedef enum logic {
      OP_ALLOC   = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_INUSE = 2'd2,
      STATUS_FULL  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_BIT
   } state_type;

   typedef struct packed {
      logic            empty;
      logic            full;
      logic [HW_W-1:0] count;
   } fifo_status_type;

endpackage

// ----- hw/rtl/id_allocator_free_fifo_core.sv -----
// id_allocator_free_fifo_core: allocates and releases IDs, reusing released IDs in FIFO order.
// Sequencer, high-water counter and result register; instantiates idfa_bitmap and
// idfa_free_fifo. Depends on idfa_pkg.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_ready | req_operation, req_release_id
//   rsp     | out       | rsp_valid/rsp_ready | rsp_granted_id, rsp_status
//
// Steps per item: a fresh allocate from the high-water counter and range or exhausted
// errors on a request finish in the idle state; a release does a bitmap read, then a write
// and FIFO push; an allocate from the free list does a FIFO read, bitmap read, bitmap write.
// The registered reads of the bitmap and FIFO memories set these steps.
// Reset needs no memory sweep: bitmap entries at or above the high-water mark are never
// read, and every entry below it has been written.
// A stalled result holds the sequencer; a new item is taken once the result register
// is empty or is being emptied in the same cycle.
module id_allocator_free_fifo_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [9:0]  req_release_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [9:0]  rsp_granted_id,
   output logic [1:0]  rsp_status
);

   localparam int ID_W  = idfa_pkg::ID_W;
   localparam int HW_W  = idfa_pkg::HW_W;
   localparam int CMP_W = idfa_pkg::CMP_W;
   localparam logic [HW_W-1:0] HW_MAX = HW_W'(idfa_pkg::MAX_IDS);

   idfa_pkg::state_type       state_ff, state_in;
   idfa_pkg::op_type          op_ff, op_in;
   logic [ID_W-1:0]           cur_id_ff, cur_id_in;
   logic [HW_W-1:0]           hw_ff, hw_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [9:0]                rsp_id_ff, rsp_id_in;
   idfa_pkg::status_type      rsp_status_ff, rsp_status_in;

   logic                      out_free;
   logic                      accept;
   logic                      req_is_rel;
   logic [CMP_W-1:0]          rel_ext;
   logic                      rel_in_range;
   logic [ID_W-1:0]           rel_id;
   logic                      pop_in_range;
   logic                      hw_at_max;

   logic                      load;
   logic [9:0]                load_id;
   idfa_pkg::status_type      load_status;

   logic                      bm_rd_en;
   logic [ID_W-1:0]           bm_rd_addr;
   logic                      bm_rd_data;
   logic                      bm_wr_en;
   logic [ID_W-1:0]           bm_wr_addr;
   logic                      bm_wr_data;

   logic                      fifo_push;
   logic                      fifo_pop;
   logic [ID_W-1:0]           fifo_pop_id;
   idfa_pkg::fifo_status_type fifo_status;

   idfa_bitmap u_bitmap (
      .clock   (clock),
      .rd_en   (bm_rd_en),
      .rd_addr (bm_rd_addr),
      .rd_data (bm_rd_data),
      .wr_en   (bm_wr_en),
      .wr_addr (bm_wr_addr),
      .wr_data (bm_wr_data)
   );

   idfa_free_fifo u_free_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (fifo_push),
      .push_id (cur_id_ff),
      .pop     (fifo_pop),
      .pop_id  (fifo_pop_id),
      .status  (fifo_status)
   );

   // Handshake and range checks
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign req_ready    = (state_ff == idfa_pkg::ST_IDLE) && out_free;
   assign accept       = req_valid && req_ready;
   assign req_is_rel   = (req_operation == idfa_pkg::OP_RELEASE);
   assign rel_ext      = CMP_W'(req_release_id);
   assign rel_in_range = rel_ext < CMP_W'(hw_ff);
   assign rel_id       = rel_ext[ID_W-1:0];
   assign pop_in_range = HW_W'(fifo_pop_id) < hw_ff;
   assign hw_at_max    = (hw_ff == HW_MAX);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         idfa_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_is_rel) begin
                  if (rel_in_range) begin
                     state_in = idfa_pkg::ST_BIT;
                  end
               end else if (!fifo_status.empty) begin
                  state_in = idfa_pkg::ST_POP;
               end
            end
         end
         idfa_pkg::ST_POP: begin
            if (pop_in_range) begin
               state_in = idfa_pkg::ST_BIT;
            end else if (out_free) begin
               state_in = idfa_pkg::ST_IDLE;
            end
         end
         idfa_pkg::ST_BIT: begin
            if (out_free) begin
               state_in = idfa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = idfa_pkg::ST_IDLE;
         end
      endcase
   end

   // Memory controls, counter update and result load
   always_comb begin
      op_in       = op_ff;
      cur_id_in   = cur_id_ff;
      hw_in       = hw_ff;
      bm_rd_en    = 1'b0;
      bm_rd_addr  = cur_id_ff;
      bm_wr_en    = 1'b0;
      bm_wr_addr  = cur_id_ff;
      bm_wr_data  = 1'b0;
      fifo_push   = 1'b0;
      fifo_pop    = 1'b0;
      load        = 1'b0;
      load_id     = '0;
      load_status = idfa_pkg::STATUS_OK;
      case (state_ff)
         idfa_pkg::ST_IDLE: begin
            if (accept) begin
               op_in     = idfa_pkg::op_type'(req_operation);
               cur_id_in = rel_id;
               if (req_is_rel) begin
                  if (rel_in_range) begin
                     bm_rd_en   = 1'b1;
                     bm_rd_addr = rel_id;
                  end else begin
                     load        = 1'b1;
                     load_status = idfa_pkg::STATUS_RANGE;
                  end
               end else if (!fifo_status.empty) begin
                  fifo_pop = 1'b1;
               end else if (hw_at_max) begin
                  load        = 1'b1;
                  load_status = idfa_pkg::STATUS_FULL;
               end else begin
                  // Issue a never-used ID from the high-water counter
                  bm_wr_en   = 1'b1;
                  bm_wr_addr = hw_ff[ID_W-1:0];
                  bm_wr_data = 1'b1;
                  hw_in      = hw_ff + 1'b1;
                  load       = 1'b1;
                  load_id    = 10'(CMP_W'(hw_ff));
               end
            end
         end
         idfa_pkg::ST_POP: begin
            cur_id_in = fifo_pop_id;
            if (pop_in_range) begin
               bm_rd_en   = 1'b1;
               bm_rd_addr = fifo_pop_id;
            end else if (out_free) begin
               load        = 1'b1;
               load_status = idfa_pkg::STATUS_RANGE;
            end
         end
         idfa_pkg::ST_BIT: begin
            if (out_free) begin
               load = 1'b1;
               if (op_ff == idfa_pkg::OP_ALLOC) begin
                  if (bm_rd_data) begin
                     load_status = idfa_pkg::STATUS_INUSE;
                  end else begin
                     bm_wr_en   = 1'b1;
                     bm_wr_data = 1'b1;
                     load_id    = 10'(CMP_W'(cur_id_ff));
                  end
               end else begin
                  if (!bm_rd_data) begin
                     load_status = idfa_pkg::STATUS_INUSE;
                  end else begin
                     // Clear the bit and queue the ID; drop the push when full
                     bm_wr_en  = 1'b1;
                     fifo_push = !fifo_status.full;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_id_in     = load_id;
         rsp_status_in = load_status;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= idfa_pkg::ST_IDLE;
         hw_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hw_ff        <= hw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      cur_id_ff     <= cur_id_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_granted_id = rsp_id_ff;
   assign rsp_status     = rsp_status_ff;

   // High-water mark never passes the ID space
   a_hw_bound: assert property (@(posedge clock) disable iff (reset)
      hw_ff <= HW_MAX)
      else $error("high-water mark beyond ID space");

   // Queued IDs are distinct and issued, so the queue never outgrows the high-water mark
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_status.count <= hw_ff)
      else $error("free list holds more IDs than were issued");

   // The bitmap is only checked for IDs below the high-water mark
   a_bit_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == idfa_pkg::ST_BIT |-> HW_W'(cur_id_ff) < hw_ff)
      else $error("bitmap read beyond high-water mark");

   // Failed allocates and all releases return ID zero
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != idfa_pkg::STATUS_OK || op_ff == idfa_pkg::OP_RELEASE)
      && state_ff == idfa_pkg::ST_IDLE |-> rsp_id_ff == '0)
      else $error("non-zero ID on a failed or release result");

   // An exhausted allocator reports full only when the counter is at its end
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      load && load_status == idfa_pkg::STATUS_FULL |-> hw_at_max && fifo_status.empty)
      else $error("full status with IDs left");

endmodule

// ----- hw/rtl/idfa_bitmap.sv -----
// idfa_bitmap: in-use bitmap, one bit per ID, with a synchronous (registered) read.
// One write port and one read port; read data holds until the next read.
// Depends on idfa_pkg.
module idfa_bitmap (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [idfa_pkg::ID_W-1:0] rd_addr,
   output logic                     rd_data,
   input  logic                     wr_en,
   input  logic [idfa_pkg::ID_W-1:0] wr_addr,
   input  logic                     wr_data
);

   logic mem [idfa_pkg::MAX_IDS];
   logic rd_data_ff;

   // Write one bit
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Register read data, hold it between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/idfa_free_fifo.sv -----
// idfa_free_fifo: circular queue of released IDs held in a synchronous memory.
// Pop data appears in the cycle after the pop and holds until the next pop.
// Depends on idfa_pkg.
module idfa_free_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [idfa_pkg::ID_W-1:0]     push_id,
   input  logic                          pop,
   output logic [idfa_pkg::ID_W-1:0]     pop_id,
   output idfa_pkg::fifo_status_type     status
);

   localparam logic [idfa_pkg::ID_W-1:0] LAST_SLOT = idfa_pkg::ID_W'(idfa_pkg::MAX_IDS - 1);
   localparam logic [idfa_pkg::HW_W-1:0] FULL_CNT  = idfa_pkg::HW_W'(idfa_pkg::MAX_IDS);

   logic [idfa_pkg::ID_W-1:0] mem [idfa_pkg::MAX_IDS];
   logic [idfa_pkg::ID_W-1:0] pop_id_ff;
   logic [idfa_pkg::ID_W-1:0] head_ff, head_in;
   logic [idfa_pkg::ID_W-1:0] tail_ff, tail_in;
   logic [idfa_pkg::HW_W-1:0] count_ff, count_in;

   // Advance pointers and count
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (pop) begin
         head_in = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
      end
      if (push) begin
         tail_in = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Write at tail, read at head
   always_ff @(posedge clock) begin
      if (push) begin
         mem[tail_ff] <= push_id;
      end
      if (pop) begin
         pop_id_ff <= mem[head_ff];
      end
   end

   assign pop_id       = pop_id_ff;
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == FULL_CNT);
   assign status.count = count_ff;

endmodule
